### hdl/three_sum_zero_two_pointer_macros.svh
// Assertion macros for the zero-sum triplet finder.
`ifndef THREE_SUM_ZERO_TWO_POINTER_MACROS_SVH
`define THREE_SUM_ZERO_TWO_POINTER_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define TSZP_ASSERT_NOW(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tszp assertion failed");

// Same-cycle implication.
`define TSZP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tszp assertion failed");

// Next-cycle implication.
`define TSZP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tszp assertion failed");

`endif

### hdl/tszp_pkg.sv
// Package: sizes, microcode encoding and the microprogram of the triplet finder.
`timescale 1ns / 1ps
`default_nettype none

package tszp_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int MAX_RESULTS  = 64;
   localparam int VALUE_WIDTH  = 16;

   localparam int IDX_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
   localparam int RES_W   = $clog2(MAX_RESULTS + 1);
   localparam int RADDR_W = $clog2(MAX_RESULTS);
   localparam int SUM_W   = VALUE_WIDTH + 2;
   localparam int TRIP_W  = 3 * VALUE_WIDTH;
   localparam int STEP_W  = 5;

   // Microprogram step addresses
   localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
   localparam logic [STEP_W-1:0] ST_SORT  = 5'd1;
   localparam logic [STEP_W-1:0] ST_SJ    = 5'd2;
   localparam logic [STEP_W-1:0] ST_SRD   = 5'd3;
   localparam logic [STEP_W-1:0] ST_SCMP  = 5'd4;
   localparam logic [STEP_W-1:0] ST_SWI   = 5'd5;
   localparam logic [STEP_W-1:0] ST_SWJ   = 5'd6;
   localparam logic [STEP_W-1:0] ST_SINCJ = 5'd7;
   localparam logic [STEP_W-1:0] ST_SINCI = 5'd8;
   localparam logic [STEP_W-1:0] ST_SRCH  = 5'd9;
   localparam logic [STEP_W-1:0] ST_ILOOP = 5'd10;
   localparam logic [STEP_W-1:0] ST_ISET  = 5'd11;
   localparam logic [STEP_W-1:0] ST_JK    = 5'd12;
   localparam logic [STEP_W-1:0] ST_SUM   = 5'd13;
   localparam logic [STEP_W-1:0] ST_LT    = 5'd14;
   localparam logic [STEP_W-1:0] ST_GT    = 5'd15;
   localparam logic [STEP_W-1:0] ST_REC   = 5'd16;
   localparam logic [STEP_W-1:0] ST_DJ    = 5'd17;
   localparam logic [STEP_W-1:0] ST_DJC   = 5'd18;
   localparam logic [STEP_W-1:0] ST_DJI   = 5'd19;
   localparam logic [STEP_W-1:0] ST_DK    = 5'd20;
   localparam logic [STEP_W-1:0] ST_DKC   = 5'd21;
   localparam logic [STEP_W-1:0] ST_DKD   = 5'd22;
   localparam logic [STEP_W-1:0] ST_JINC  = 5'd23;
   localparam logic [STEP_W-1:0] ST_KDEC  = 5'd24;
   localparam logic [STEP_W-1:0] ST_NEXTI = 5'd25;
   localparam logic [STEP_W-1:0] ST_EMIT  = 5'd26;
   localparam logic [STEP_W-1:0] ST_EWAIT = 5'd27;
   localparam logic [STEP_W-1:0] ST_ESHOW = 5'd28;
   localparam logic [STEP_W-1:0] ST_END   = 5'd29;
   localparam logic [STEP_W-1:0] ST_NWAIT = 5'd30;
   localparam logic [STEP_W-1:0] ST_NSHOW = 5'd31;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_SORT_INIT,
      ACT_SET_J,
      ACT_RD_IJ,
      ACT_WR_I,
      ACT_WR_J,
      ACT_INC_J,
      ACT_INC_I,
      ACT_CLR_I,
      ACT_RD_IPREV,
      ACT_SET_JK,
      ACT_RD_JK,
      ACT_SUM,
      ACT_RECORD,
      ACT_RD_J,
      ACT_RD_K,
      ACT_DEC_K,
      ACT_CLR_R,
      ACT_RD_T,
      ACT_SHOW_T,
      ACT_SHOW_NONE,
      ACT_END_RUN
   } act_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_WAIT,
      C_I1_GE_N,
      C_B_GE_A,
      C_J1_LT_N,
      C_I2_GE_N,
      C_DUP,
      C_J_GE_K,
      C_S_LT0,
      C_S_GT0,
      C_A_NE_VJ,
      C_B_NE_VK,
      C_KEPT0,
      C_OUT_BUSY,
      C_R_NOT_LAST
   } cond_type;

   // One control word: jump to target when cond holds, else fall through.
   typedef struct packed {
      logic                ready;
      act_type             act;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{1'b0, ACT_NONE, C_ALWAYS, ST_IDLE};
      case (step)
         ST_IDLE:  w = '{1'b1, ACT_NONE,      C_WAIT,       ST_IDLE};
         // exchange sort
         ST_SORT:  w = '{1'b0, ACT_SORT_INIT, C_NEVER,      ST_IDLE};
         ST_SJ:    w = '{1'b0, ACT_SET_J,     C_I1_GE_N,    ST_SRCH};
         ST_SRD:   w = '{1'b0, ACT_RD_IJ,     C_NEVER,      ST_IDLE};
         ST_SCMP:  w = '{1'b0, ACT_NONE,      C_B_GE_A,     ST_SINCJ};
         ST_SWI:   w = '{1'b0, ACT_WR_I,      C_NEVER,      ST_IDLE};
         ST_SWJ:   w = '{1'b0, ACT_WR_J,      C_NEVER,      ST_IDLE};
         ST_SINCJ: w = '{1'b0, ACT_INC_J,     C_J1_LT_N,    ST_SRD};
         ST_SINCI: w = '{1'b0, ACT_INC_I,     C_ALWAYS,     ST_SJ};
         // two-pointer scan
         ST_SRCH:  w = '{1'b0, ACT_CLR_I,     C_NEVER,      ST_IDLE};
         ST_ILOOP: w = '{1'b0, ACT_RD_IPREV,  C_I2_GE_N,    ST_EMIT};
         ST_ISET:  w = '{1'b0, ACT_SET_JK,    C_DUP,        ST_NEXTI};
         ST_JK:    w = '{1'b0, ACT_RD_JK,     C_J_GE_K,     ST_NEXTI};
         ST_SUM:   w = '{1'b0, ACT_SUM,       C_NEVER,      ST_IDLE};
         ST_LT:    w = '{1'b0, ACT_NONE,      C_S_LT0,      ST_JINC};
         ST_GT:    w = '{1'b0, ACT_NONE,      C_S_GT0,      ST_KDEC};
         ST_REC:   w = '{1'b0, ACT_RECORD,    C_NEVER,      ST_IDLE};
         ST_DJ:    w = '{1'b0, ACT_RD_J,      C_J_GE_K,     ST_JK};
         ST_DJC:   w = '{1'b0, ACT_NONE,      C_A_NE_VJ,    ST_DK};
         ST_DJI:   w = '{1'b0, ACT_INC_J,     C_ALWAYS,     ST_DJ};
         ST_DK:    w = '{1'b0, ACT_RD_K,      C_J_GE_K,     ST_JK};
         ST_DKC:   w = '{1'b0, ACT_NONE,      C_B_NE_VK,    ST_JK};
         ST_DKD:   w = '{1'b0, ACT_DEC_K,     C_ALWAYS,     ST_DK};
         ST_JINC:  w = '{1'b0, ACT_INC_J,     C_ALWAYS,     ST_JK};
         ST_KDEC:  w = '{1'b0, ACT_DEC_K,     C_ALWAYS,     ST_JK};
         ST_NEXTI: w = '{1'b0, ACT_INC_I,     C_ALWAYS,     ST_ILOOP};
         // result emission
         ST_EMIT:  w = '{1'b0, ACT_CLR_R,     C_KEPT0,      ST_NWAIT};
         ST_EWAIT: w = '{1'b0, ACT_RD_T,      C_OUT_BUSY,   ST_EWAIT};
         ST_ESHOW: w = '{1'b0, ACT_SHOW_T,    C_R_NOT_LAST, ST_EWAIT};
         ST_END:   w = '{1'b0, ACT_END_RUN,   C_ALWAYS,     ST_IDLE};
         ST_NWAIT: w = '{1'b0, ACT_NONE,      C_OUT_BUSY,   ST_NWAIT};
         ST_NSHOW: w = '{1'b0, ACT_SHOW_NONE, C_ALWAYS,     ST_END};
         default:  w = '{1'b0, ACT_NONE,      C_ALWAYS,     ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hdl/three_sum_zero_two_pointer.sv
// Zero-sum triplet finder: microcoded sort and two-pointer scan over a small element store.
//
// Input stream (req_*): one signed element per transfer in req_tdata; req_tlast marks
// the final element of a run. Up to 16 elements are kept; more are dropped and the run
// is flagged truncated. Elements load at one per cycle while the sequencer is idle.
// After the last transfer req_tready stays low until the run's final result has been
// loaded into the output register.
// The element store is sorted (exchange sort), then scanned with two pointers (at most
// about n*n/2 pointer steps, with duplicates skipped after each match). Both phases
// are bound by the two read ports of the element store, which the microprogram uses
// once per compare.
// Output stream (rsp_*): one transfer per distinct zero-sum triplet, ascending, in
// lexicographic order, rsp_tlast on the final one. Up to 64 triplets are buffered; the
// rest are dropped and flag truncated. With no triplet a single transfer with found
// clear and rsp_tlast set is sent.
// A stalled receiver holds the result register; the sequencer waits for it to drain.
// Reset clears the element and result counts, flags, output valid and sequencer; stored values are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module three_sum_zero_two_pointer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,   // [15:0] element_value
   input  wire logic                            req_tlast,   // last_element
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [3*tszp_pkg::VALUE_WIDTH-1:0]   rsp_tdata,   // first, second, third value
   output logic                                 rsp_tlast,   // last_result
   output logic [1:0]                           rsp_tuser    // [0] found, [1] truncated
);
   import tszp_pkg::*;

   ucode_type ctl;
   logic      accept;
   logic      cond_true;

   logic [STEP_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic signed [VALUE_WIDTH-1:0] a_ff, a_in;
   logic signed [VALUE_WIDTH-1:0] vj_ff, vj_in;
   logic signed [VALUE_WIDTH-1:0] vk_ff, vk_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [RES_W-1:0]   kept_ff, kept_in;
   logic               over_ff, over_in;
   logic [RADDR_W-1:0] r_ff, r_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TRIP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_trunc_ff, rsp_trunc_in;

   // element store: one write port, two registered read ports
   logic signed [VALUE_WIDTH-1:0] store_ff [MAX_ELEMENTS];
   logic signed [VALUE_WIDTH-1:0] rda_ff, rdb_ff;
   logic                          st_we, rda_en, rdb_en;
   logic [ADDR_W-1:0]             st_wa, st_ra, st_rb;
   logic signed [VALUE_WIDTH-1:0] st_wd;

   // triplet buffer
   logic [TRIP_W-1:0]  trip_ff [MAX_RESULTS];
   logic [TRIP_W-1:0]  trip_rd_ff;
   logic               tr_we, tr_re;

   logic [IDX_W:0]     i_ext, j_ext, n_ext;
   logic               kept_room;
   logic               r_is_last;
   logic               showing;
   logic               counts_ok;

   assign ctl        = ucode(step_ff);
   assign req_tready = ctl.ready;
   assign accept     = req_tvalid & req_tready;

   assign i_ext     = {1'b0, i_ff};
   assign j_ext     = {1'b0, j_ff};
   assign n_ext     = {1'b0, cnt_ff};
   assign kept_room = kept_ff < RES_W'(MAX_RESULTS);
   assign r_is_last = (RES_W'(r_ff) + RES_W'(1)) == kept_ff;

   // branch condition
   always_comb begin
      case (ctl.cond)
         C_NEVER:      cond_true = 1'b0;
         C_ALWAYS:     cond_true = 1'b1;
         C_WAIT:       cond_true = !(accept && req_tlast);
         C_I1_GE_N:    cond_true = (i_ext + (IDX_W+1)'(1)) >= n_ext;
         C_B_GE_A:     cond_true = rdb_ff >= rda_ff;
         C_J1_LT_N:    cond_true = (j_ext + (IDX_W+1)'(1)) < n_ext;
         C_I2_GE_N:    cond_true = (i_ext + (IDX_W+1)'(2)) >= n_ext;
         C_DUP:        cond_true = (i_ff != '0) && (rda_ff == rdb_ff);
         C_J_GE_K:     cond_true = j_ff >= k_ff;
         C_S_LT0:      cond_true = sum_ff[SUM_W-1];
         C_S_GT0:      cond_true = !sum_ff[SUM_W-1] && (sum_ff != '0);
         C_A_NE_VJ:    cond_true = rda_ff != vj_ff;
         C_B_NE_VK:    cond_true = rdb_ff != vk_ff;
         C_KEPT0:      cond_true = kept_ff == '0;
         C_OUT_BUSY:   cond_true = rsp_valid_ff && !rsp_tready;
         C_R_NOT_LAST: cond_true = !r_is_last;
         default:      cond_true = 1'b0;
      endcase
   end

   // step counter
   always_comb begin
      if (cond_true) begin
         step_in = ctl.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // datapath controls and next values
   always_comb begin
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      a_in    = a_ff;
      vj_in   = vj_ff;
      vk_in   = vk_ff;
      sum_in  = sum_ff;
      kept_in = kept_ff;
      over_in = over_ff;
      r_in    = r_ff;
      st_we   = 1'b0;
      st_wa   = cnt_ff[ADDR_W-1:0];
      st_wd   = req_tdata[VALUE_WIDTH-1:0];
      st_ra   = i_ff[ADDR_W-1:0];
      st_rb   = j_ff[ADDR_W-1:0];
      rda_en  = 1'b0;
      rdb_en  = 1'b0;
      tr_we   = 1'b0;
      tr_re   = 1'b0;

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_found_in = rsp_found_ff;
      rsp_trunc_in = rsp_trunc_ff;

      if (accept) begin
         if (cnt_ff < IDX_W'(MAX_ELEMENTS)) begin
            st_we  = 1'b1;
            cnt_in = cnt_ff + IDX_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      case (ctl.act)
         ACT_SORT_INIT: begin
            i_in    = '0;
            kept_in = '0;
            over_in = 1'b0;
         end
         ACT_SET_J: j_in = i_ff + IDX_W'(1);
         ACT_RD_IJ: begin
            rda_en = 1'b1;
            rdb_en = 1'b1;
         end
         ACT_WR_I: begin
            st_we = 1'b1;
            st_wa = i_ff[ADDR_W-1:0];
            st_wd = rdb_ff;
         end
         ACT_WR_J: begin
            st_we = 1'b1;
            st_wa = j_ff[ADDR_W-1:0];
            st_wd = rda_ff;
         end
         ACT_INC_J: j_in = j_ff + IDX_W'(1);
         ACT_INC_I: i_in = i_ff + IDX_W'(1);
         ACT_CLR_I: i_in = '0;
         ACT_RD_IPREV: begin
            // v[i] on port A, v[i-1] on port B for the duplicate check
            st_rb  = i_ff[ADDR_W-1:0] - ADDR_W'(1);
            rda_en = 1'b1;
            rdb_en = 1'b1;
         end
         ACT_SET_JK: begin
            a_in = rda_ff;
            j_in = i_ff + IDX_W'(1);
            k_in = cnt_ff - IDX_W'(1);
         end
         ACT_RD_JK: begin
            st_ra  = j_ff[ADDR_W-1:0];
            st_rb  = k_ff[ADDR_W-1:0];
            rda_en = 1'b1;
            rdb_en = 1'b1;
         end
         ACT_SUM: sum_in = SUM_W'(a_ff) + SUM_W'(rda_ff) + SUM_W'(rdb_ff);
         ACT_RECORD: begin
            vj_in = rda_ff;
            vk_in = rdb_ff;
            j_in  = j_ff + IDX_W'(1);
            k_in  = k_ff - IDX_W'(1);
            if (kept_room) begin
               tr_we   = 1'b1;
               kept_in = kept_ff + RES_W'(1);
            end else begin
               over_in = 1'b1;
            end
         end
         ACT_RD_J: begin
            st_ra  = j_ff[ADDR_W-1:0];
            rda_en = 1'b1;
         end
         ACT_RD_K: begin
            st_rb  = k_ff[ADDR_W-1:0];
            rdb_en = 1'b1;
         end
         ACT_DEC_K: k_in = k_ff - IDX_W'(1);
         ACT_CLR_R: r_in = '0;
         ACT_RD_T:  tr_re = 1'b1;
         ACT_SHOW_T: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = trip_rd_ff;
            rsp_found_in = 1'b1;
            rsp_last_in  = r_is_last;
            rsp_trunc_in = ovf_ff | over_ff;
            r_in         = r_ff + RADDR_W'(1);
         end
         ACT_SHOW_NONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_found_in = 1'b0;
            rsp_last_in  = 1'b1;
            rsp_trunc_in = ovf_ff | over_ff;
         end
         ACT_END_RUN: begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // element store
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_ff[st_wa] <= st_wd;
      end
      if (rda_en) begin
         rda_ff <= store_ff[st_ra];
      end
      if (rdb_en) begin
         rdb_ff <= store_ff[st_rb];
      end
   end

   // triplet buffer, entries held as {third, second, first}
   always_ff @(posedge clock) begin
      if (tr_we) begin
         trip_ff[kept_ff[RADDR_W-1:0]] <= {rdb_ff, rda_ff, a_ff};
      end
      if (tr_re) begin
         trip_rd_ff <= trip_ff[r_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         kept_ff      <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         kept_ff      <= kept_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      a_ff         <= a_in;
      vj_ff        <= vj_in;
      vk_ff        <= vk_in;
      sum_ff       <= sum_in;
      r_ff         <= r_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_trunc_ff, rsp_found_ff};

   assign showing   = (ctl.act == ACT_SHOW_T) || (ctl.act == ACT_SHOW_NONE);
   assign counts_ok = (kept_ff <= RES_W'(MAX_RESULTS)) && (cnt_ff <= IDX_W'(MAX_ELEMENTS));

`include "three_sum_zero_two_pointer_macros.svh"

   `TSZP_ASSERT_IMPL(a_show_into_free_reg, clock, reset, showing, !rsp_valid_ff)
   `TSZP_ASSERT_NEXT(a_last_starts_sort, clock, reset, accept && req_tlast, step_ff == ST_SORT)
   `TSZP_ASSERT_NOW(a_counts_in_range, clock, reset, counts_ok)

endmodule

`default_nettype wire
